// ----- hw/rtl/rectangle_geometry_unit_defines.svh -----
// Assertion macros for the rectangle geometry unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RECTANGLE_GEOMETRY_UNIT_DEFINES_SVH
`define RECTANGLE_GEOMETRY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RGU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RGU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RGU_ASSERT_SAME(lbl, ante, cons, msg)
`define RGU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/rgu_pkg.sv -----
`timescale 1ns / 1ps
package rgu_pkg;

  typedef enum logic [2:0] {
    CMD_INTERSECT  = 3'd0,
    CMD_JOIN       = 3'd1,
    CMD_MOVE       = 3'd2,
    CMD_INNER      = 3'd3,
    CMD_NEAR_INNER = 3'd4,
    CMD_CROSSED    = 3'd5,
    CMD_SUBTRACT   = 3'd6,
    CMD_NORMALIZE  = 3'd7
  } cmd_t;

  localparam int unsigned MAX_PIECES = 4;

  typedef logic [1:0] more_t;

  typedef struct packed {
    logic  valid;
    logic  test_flag;
    logic  rect_valid;
    logic  saturated;
    more_t more;
  } batch_t;

endpackage

// ----- hw/rtl/rgu_calc.sv -----
`timescale 1ns / 1ps
module rgu_calc #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  logic [2:0]            command,
  input  logic [COORD_BITS-1:0] a_left,
  input  logic [COORD_BITS-1:0] a_right,
  input  logic [COORD_BITS-1:0] a_top,
  input  logic [COORD_BITS-1:0] a_bottom,
  input  logic [COORD_BITS-1:0] b_left,
  input  logic [COORD_BITS-1:0] b_right,
  input  logic [COORD_BITS-1:0] b_top,
  input  logic [COORD_BITS-1:0] b_bottom,
  input  logic [COORD_BITS-1:0] shift_x,
  input  logic [COORD_BITS-1:0] shift_y,
  input  logic [COORD_BITS-1:0] margin,
  output rgu_pkg::batch_t       batch,
  output logic [rgu_pkg::MAX_PIECES-1:0][COORD_BITS-1:0] list_left,
  output logic [rgu_pkg::MAX_PIECES-1:0][COORD_BITS-1:0] list_right,
  output logic [rgu_pkg::MAX_PIECES-1:0][COORD_BITS-1:0] list_top,
  output logic [rgu_pkg::MAX_PIECES-1:0][COORD_BITS-1:0] list_bottom
);

  localparam int W = COORD_BITS;
  localparam int NP = rgu_pkg::MAX_PIECES;

  typedef logic signed [W-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t r;
    coord_t t;
    coord_t b;
  } rect_t;

  function automatic coord_t smin(input coord_t x, input coord_t y);
    return (x > y) ? y : x;
  endfunction

  function automatic coord_t smax(input coord_t x, input coord_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic logic [W:0] sat_fix(input logic signed [W:0] s);
    if (s[W] != s[W-1]) begin
      return {1'b1, s[W], {(W-1){~s[W]}}};
    end
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] sat_add(input coord_t x, input coord_t y);
    return sat_fix({x[W-1], x} + {y[W-1], y});
  endfunction

  function automatic logic [W:0] sat_sub(input coord_t x, input coord_t y);
    return sat_fix({x[W-1], x} - {y[W-1], y});
  endfunction

  function automatic rect_t cut(input rect_t a, input rect_t q);
    rect_t o;
    o = a;
    if (a.l > q.r) begin
      o.r = a.l;
    end else if (a.r < q.l) begin
      o.l = a.r;
    end else begin
      o.l = smax(a.l, q.l);
      o.r = smin(a.r, q.r);
    end
    if (a.t > q.b) begin
      o.b = a.t;
    end else if (a.b < q.t) begin
      o.t = a.b;
    end else begin
      o.t = smax(a.t, q.t);
      o.b = smin(a.b, q.b);
    end
    return o;
  endfunction

  function automatic rect_t norm(input coord_t x1, input coord_t y1,
                                 input coord_t x2, input coord_t y2);
    rect_t o;
    o.l = smin(x1, x2);
    o.r = smax(x1, x2);
    o.t = smin(y1, y2);
    o.b = smax(y1, y2);
    return o;
  endfunction

  // Stage 1: captured transaction.
  logic          v1;
  rgu_pkg::cmd_t c1;
  rect_t         a1, b1;
  coord_t        sx1, sy1, m1;

  // Stage 2: sums, join and normalize.
  logic          v2;
  rgu_pkg::cmd_t c2;
  rect_t         a2, b2, o2, r2;
  logic          s2;

  // Stage 3: intersection.
  logic          v3;
  rgu_pkg::cmd_t c3;
  rect_t         a3, b3, i3, r3;
  logic          s3;

  // Stage 4: tests and remainder pieces.
  logic          v4;
  rect_t         sg4;
  logic          flag4, rv4, sat4, usep4;
  rect_t [NP-1:0] pc4;
  logic  [NP-1:0] mask4;

  // Stage 5: packed result list.
  logic          v5;
  rect_t [NP-1:0] list5;
  logic          flag5, rv5, sat5;
  rgu_pkg::more_t more5;

  logic [W:0] mv_l, mv_r, mv_t, mv_b;
  logic [W:0] gr_l, gr_r, gr_t, gr_b;
  rect_t      moved, grown, joined, normed;
  rect_t      o2_next, r2_next;
  logic       s2_next;

  always_comb begin
    mv_l = sat_add(a1.l, sx1);
    mv_r = sat_add(a1.r, sx1);
    mv_t = sat_add(a1.t, sy1);
    mv_b = sat_add(a1.b, sy1);
    gr_l = sat_sub(a1.l, m1);
    gr_t = sat_sub(a1.t, m1);
    gr_r = sat_add(a1.r, m1);
    gr_b = sat_add(a1.b, m1);
    moved  = '{l: mv_l[W-1:0], r: mv_r[W-1:0], t: mv_t[W-1:0], b: mv_b[W-1:0]};
    grown  = '{l: gr_l[W-1:0], r: gr_r[W-1:0], t: gr_t[W-1:0], b: gr_b[W-1:0]};
    joined = '{l: smin(a1.l, b1.l), r: smax(a1.r, b1.r),
               t: smin(a1.t, b1.t), b: smax(a1.b, b1.b)};
    normed = norm(a1.l, a1.t, a1.r, a1.b);
    o2_next = a1;
    r2_next = a1;
    s2_next = 1'b0;
    case (c1)
      rgu_pkg::CMD_JOIN: begin
        r2_next = joined;
      end
      rgu_pkg::CMD_MOVE: begin
        r2_next = moved;
        s2_next = mv_l[W] | mv_r[W] | mv_t[W] | mv_b[W];
      end
      rgu_pkg::CMD_NEAR_INNER: begin
        o2_next = grown;
        s2_next = gr_l[W] | gr_r[W] | gr_t[W] | gr_b[W];
      end
      rgu_pkg::CMD_NORMALIZE: begin
        r2_next = normed;
      end
      default: begin
        r2_next = a1;
      end
    endcase
  end

  logic  same_b, same_a, empty_i;
  rect_t sg4_next;
  logic  flag4_next, rv4_next, usep4_next;
  rect_t [NP-1:0] pc4_next;
  logic  [NP-1:0] mask4_next;

  always_comb begin
    same_b  = (i3 == b3);
    same_a  = (i3 == a3);
    empty_i = (i3.l == i3.r) || (i3.t == i3.b);
    pc4_next[0] = norm(a3.l, a3.t, a3.r, i3.t);
    pc4_next[1] = norm(a3.l, i3.b, a3.r, a3.b);
    pc4_next[2] = norm(a3.l, i3.t, i3.l, i3.b);
    pc4_next[3] = norm(i3.r, i3.t, a3.r, i3.b);
    mask4_next  = {a3.r != i3.r, a3.l != i3.l, a3.b != i3.b, a3.t != i3.t};
    sg4_next    = r3;
    flag4_next  = 1'b0;
    rv4_next    = 1'b1;
    usep4_next  = 1'b0;
    case (c3)
      rgu_pkg::CMD_INTERSECT: begin
        sg4_next = i3;
      end
      rgu_pkg::CMD_INNER, rgu_pkg::CMD_NEAR_INNER: begin
        sg4_next   = '0;
        flag4_next = same_b;
        rv4_next   = 1'b0;
      end
      rgu_pkg::CMD_CROSSED: begin
        sg4_next   = '0;
        flag4_next = !empty_i;
        rv4_next   = 1'b0;
      end
      rgu_pkg::CMD_SUBTRACT: begin
        if (empty_i) begin
          sg4_next = a3;
        end else if (same_a) begin
          sg4_next = '0;
          rv4_next = 1'b0;
        end else begin
          usep4_next = 1'b1;
        end
      end
      default: begin
        sg4_next = r3;
      end
    endcase
  end

  rect_t [NP-1:0] list5_next;
  logic  [2:0]    fill;

  always_comb begin
    list5_next    = '0;
    list5_next[0] = sg4;
    fill          = 3'd0;
    if (usep4) begin
      for (int j = 0; j < NP; j++) begin
        if (mask4[j]) begin
          list5_next[fill[1:0]] = pc4[j];
          fill = fill + 3'd1;
        end
      end
    end else begin
      fill = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1  <= rgu_pkg::cmd_t'(command);
      a1  <= '{l: a_left, r: a_right, t: a_top, b: a_bottom};
      b1  <= '{l: b_left, r: b_right, t: b_top, b: b_bottom};
      sx1 <= shift_x;
      sy1 <= shift_y;
      m1  <= margin;

      c2 <= c1;
      a2 <= a1;
      b2 <= b1;
      o2 <= o2_next;
      r2 <= r2_next;
      s2 <= s2_next;

      c3 <= c2;
      a3 <= a2;
      b3 <= b2;
      i3 <= cut(o2, b2);
      r3 <= r2;
      s3 <= s2;

      sg4   <= sg4_next;
      flag4 <= flag4_next;
      rv4   <= rv4_next;
      sat4  <= s3;
      usep4 <= usep4_next;
      pc4   <= pc4_next;
      mask4 <= mask4_next;

      list5 <= list5_next;
      flag5 <= flag4;
      rv5   <= rv4;
      sat5  <= sat4;
      more5 <= rgu_pkg::more_t'(fill - 3'd1);
    end
  end

  always_comb begin
    batch.valid      = v5;
    batch.test_flag  = flag5;
    batch.rect_valid = rv5;
    batch.saturated  = sat5;
    batch.more       = more5;
    for (int k = 0; k < NP; k++) begin
      list_left[k]   = list5[k].l;
      list_right[k]  = list5[k].r;
      list_top[k]    = list5[k].t;
      list_bottom[k] = list5[k].b;
    end
  end

endmodule

// ----- hw/rtl/rectangle_geometry_unit.sv -----
`timescale 1ns / 1ps
// Channel    Handshake       Payload
// command    start / busy    command, a_*, b_*, shift_x, shift_y, margin
// result     strobe          out_*, test_flag, rect_valid, saturated, last_piece
//
// A transaction is taken at each edge with start high and busy low; the first
// result passes the compute stages and the output register, and lasts one cycle.
// Five compute stages and an output register: one transaction per cycle for
// every command except subtract, which gives one to four results, one a cycle.
// While further subtract pieces drain from the output queue, busy is high and
// the whole pipeline holds. Synchronous rst clears all valid bits and the piece count.
`include "rectangle_geometry_unit_defines.svh"
module rectangle_geometry_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   command,
  input  logic signed [COORD_BITS-1:0] a_left,
  input  logic signed [COORD_BITS-1:0] a_right,
  input  logic signed [COORD_BITS-1:0] a_top,
  input  logic signed [COORD_BITS-1:0] a_bottom,
  input  logic signed [COORD_BITS-1:0] b_left,
  input  logic signed [COORD_BITS-1:0] b_right,
  input  logic signed [COORD_BITS-1:0] b_top,
  input  logic signed [COORD_BITS-1:0] b_bottom,
  input  logic signed [COORD_BITS-1:0] shift_x,
  input  logic signed [COORD_BITS-1:0] shift_y,
  input  logic signed [COORD_BITS-1:0] margin,
  output logic                         strobe,
  output logic signed [COORD_BITS-1:0] out_left,
  output logic signed [COORD_BITS-1:0] out_right,
  output logic signed [COORD_BITS-1:0] out_top,
  output logic signed [COORD_BITS-1:0] out_bottom,
  output logic                         test_flag,
  output logic                         rect_valid,
  output logic                         saturated,
  output logic                         last_piece
);

  localparam int W = COORD_BITS;
  localparam int NP = rgu_pkg::MAX_PIECES;

  typedef struct packed {
    logic [W-1:0] l;
    logic [W-1:0] r;
    logic [W-1:0] t;
    logic [W-1:0] b;
  } rect_t;

  rgu_pkg::batch_t               batch;
  logic [NP-1:0][W-1:0]          list_left, list_right, list_top, list_bottom;
  rect_t [NP-2:0]                queue;
  rgu_pkg::more_t                remaining;
  logic                          advance;

  assign busy    = (remaining != '0);
  assign advance = !busy;

  rgu_calc #(
    .COORD_BITS (COORD_BITS)
  ) u_calc (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (start),
    .command     (command),
    .a_left      (a_left),
    .a_right     (a_right),
    .a_top       (a_top),
    .a_bottom    (a_bottom),
    .b_left      (b_left),
    .b_right     (b_right),
    .b_top       (b_top),
    .b_bottom    (b_bottom),
    .shift_x     (shift_x),
    .shift_y     (shift_y),
    .margin      (margin),
    .batch       (batch),
    .list_left   (list_left),
    .list_right  (list_right),
    .list_top    (list_top),
    .list_bottom (list_bottom)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe    <= 1'b0;
      remaining <= '0;
    end else if (busy) begin
      strobe    <= 1'b1;
      remaining <= remaining - rgu_pkg::more_t'(1);
    end else begin
      strobe    <= batch.valid;
      remaining <= batch.valid ? batch.more : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_left   <= queue[0].l;
      out_right  <= queue[0].r;
      out_top    <= queue[0].t;
      out_bottom <= queue[0].b;
      last_piece <= (remaining == rgu_pkg::more_t'(1));
      for (int k = 0; k < NP - 2; k++) begin
        queue[k] <= queue[k+1];
      end
    end else begin
      out_left   <= list_left[0];
      out_right  <= list_right[0];
      out_top    <= list_top[0];
      out_bottom <= list_bottom[0];
      test_flag  <= batch.test_flag;
      rect_valid <= batch.rect_valid;
      saturated  <= batch.saturated;
      last_piece <= (batch.more == '0);
      for (int k = 0; k < NP - 1; k++) begin
        queue[k] <= '{l: list_left[k+1], r: list_right[k+1],
                      t: list_top[k+1], b: list_bottom[k+1]};
      end
    end
  end

  `RGU_ASSERT_NEXT(a_busy_emits, busy, strobe, "queued piece was not emitted")
  `RGU_ASSERT_SAME(a_more_holds, strobe && !last_piece, busy, "pieces left but not busy")
  `RGU_ASSERT_SAME(a_empty_rect, strobe && !rect_valid, (out_left == '0) && (out_right == '0) && (out_top == '0) && (out_bottom == '0) && last_piece, "invalid result with data")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int COORD_BITS = 16;
  localparam int COORD_MAX = 2 ** (COORD_BITS - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_BITS - 1));
  localparam int RANDOM_REQUESTS = 400;
  localparam int CYCLE_LIMIT = 60000;

  typedef struct packed {
    rgu_pkg::cmd_t                command;
    logic signed [COORD_BITS-1:0] a_left;
    logic signed [COORD_BITS-1:0] a_right;
    logic signed [COORD_BITS-1:0] a_top;
    logic signed [COORD_BITS-1:0] a_bottom;
    logic signed [COORD_BITS-1:0] b_left;
    logic signed [COORD_BITS-1:0] b_right;
    logic signed [COORD_BITS-1:0] b_top;
    logic signed [COORD_BITS-1:0] b_bottom;
    logic signed [COORD_BITS-1:0] shift_x;
    logic signed [COORD_BITS-1:0] shift_y;
    logic signed [COORD_BITS-1:0] margin;
  } rect_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_left;
    logic signed [COORD_BITS-1:0] out_right;
    logic signed [COORD_BITS-1:0] out_top;
    logic signed [COORD_BITS-1:0] out_bottom;
    logic                         test_flag;
    logic                         rect_valid;
    logic                         saturated;
    logic                         last_piece;
  } rect_result_t;

  typedef struct packed {
    rect_req_t    req;
    logic         has_typed;
    rect_result_t typed;
  } stim_row_t;

  typedef struct packed {
    int l;
    int r;
    int t;
    int b;
  } box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  rect_req_t drv = '0;

  logic                         busy;
  logic                         strobe;
  logic signed [COORD_BITS-1:0] out_left;
  logic signed [COORD_BITS-1:0] out_right;
  logic signed [COORD_BITS-1:0] out_top;
  logic signed [COORD_BITS-1:0] out_bottom;
  logic                         test_flag;
  logic                         rect_valid;
  logic                         saturated;
  logic                         last_piece;

  rect_result_t rects_awaited[$];
  stim_row_t    stim_table[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           sum_clamped;

  rectangle_geometry_unit #(.COORD_BITS(COORD_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (drv.command),
    .a_left    (drv.a_left),
    .a_right   (drv.a_right),
    .a_top     (drv.a_top),
    .a_bottom  (drv.a_bottom),
    .b_left    (drv.b_left),
    .b_right   (drv.b_right),
    .b_top     (drv.b_top),
    .b_bottom  (drv.b_bottom),
    .shift_x   (drv.shift_x),
    .shift_y   (drv.shift_y),
    .margin    (drv.margin),
    .strobe    (strobe),
    .out_left  (out_left),
    .out_right (out_right),
    .out_top   (out_top),
    .out_bottom(out_bottom),
    .test_flag (test_flag),
    .rect_valid(rect_valid),
    .saturated (saturated),
    .last_piece(last_piece)
  );

  always #10 clk = ~clk;

  function automatic int clamp_sum(int x, int y);
    int s;
    s = x + y;
    if (s > COORD_MAX) begin
      sum_clamped = 1'b1;
      return COORD_MAX;
    end
    if (s < COORD_MIN) begin
      sum_clamped = 1'b1;
      return COORD_MIN;
    end
    return s;
  endfunction

  // A disjoint axis collapses onto the edge of the first rectangle nearest the second.
  function automatic box_t overlap_of(box_t p, box_t q);
    box_t o;
    o = p;
    if (p.l > q.r) begin
      o.r = p.l;
    end else if (p.r < q.l) begin
      o.l = p.r;
    end else begin
      o.l = (p.l > q.l) ? p.l : q.l;
      o.r = (p.r < q.r) ? p.r : q.r;
    end
    if (p.t > q.b) begin
      o.b = p.t;
    end else if (p.b < q.t) begin
      o.t = p.b;
    end else begin
      o.t = (p.t > q.t) ? p.t : q.t;
      o.b = (p.b < q.b) ? p.b : q.b;
    end
    return o;
  endfunction

  function automatic box_t box_from_corners(int x1, int y1, int x2, int y2);
    box_t o;
    o.l = (x1 < x2) ? x1 : x2;
    o.r = (x1 < x2) ? x2 : x1;
    o.t = (y1 < y2) ? y1 : y2;
    o.b = (y1 < y2) ? y2 : y1;
    return o;
  endfunction

  function automatic bit is_hollow(box_t x);
    return x.l == x.r || x.t == x.b;
  endfunction

  function automatic void push_rect(box_t x, logic flag, logic valid, logic last);
    rect_result_t res;
    res.out_left = COORD_BITS'(x.l);
    res.out_right = COORD_BITS'(x.r);
    res.out_top = COORD_BITS'(x.t);
    res.out_bottom = COORD_BITS'(x.b);
    res.test_flag = flag;
    res.rect_valid = valid;
    res.saturated = sum_clamped;
    res.last_piece = last;
    rects_awaited.insert(rects_awaited.size(), res);
  endfunction

  function automatic void predict_rectangles(rect_req_t q);
    box_t a, b, x, zero;
    box_t pieces[4];
    int sx, sy, mg, n;
    a.l = $signed(q.a_left);
    a.r = $signed(q.a_right);
    a.t = $signed(q.a_top);
    a.b = $signed(q.a_bottom);
    b.l = $signed(q.b_left);
    b.r = $signed(q.b_right);
    b.t = $signed(q.b_top);
    b.b = $signed(q.b_bottom);
    sx = $signed(q.shift_x);
    sy = $signed(q.shift_y);
    mg = $signed(q.margin);
    zero = '0;
    sum_clamped = 1'b0;
    n = 0;
    case (q.command)
      rgu_pkg::CMD_INTERSECT: begin
        push_rect(overlap_of(a, b), 1'b0, 1'b1, 1'b1);
      end
      rgu_pkg::CMD_JOIN: begin
        x.l = (a.l < b.l) ? a.l : b.l;
        x.r = (a.r > b.r) ? a.r : b.r;
        x.t = (a.t < b.t) ? a.t : b.t;
        x.b = (a.b > b.b) ? a.b : b.b;
        push_rect(x, 1'b0, 1'b1, 1'b1);
      end
      rgu_pkg::CMD_MOVE: begin
        x.l = clamp_sum(a.l, sx);
        x.r = clamp_sum(a.r, sx);
        x.t = clamp_sum(a.t, sy);
        x.b = clamp_sum(a.b, sy);
        push_rect(x, 1'b0, 1'b1, 1'b1);
      end
      rgu_pkg::CMD_INNER: begin
        push_rect(zero, overlap_of(a, b) == b, 1'b0, 1'b1);
      end
      rgu_pkg::CMD_NEAR_INNER: begin
        x.l = clamp_sum(a.l, -mg);
        x.t = clamp_sum(a.t, -mg);
        x.r = clamp_sum(a.r, mg);
        x.b = clamp_sum(a.b, mg);
        push_rect(zero, overlap_of(x, b) == b, 1'b0, 1'b1);
      end
      rgu_pkg::CMD_CROSSED: begin
        push_rect(zero, !is_hollow(overlap_of(a, b)), 1'b0, 1'b1);
      end
      rgu_pkg::CMD_SUBTRACT: begin
        x = overlap_of(a, b);
        if (is_hollow(x)) begin
          push_rect(a, 1'b0, 1'b1, 1'b1);
        end else if (x == a) begin
          push_rect(zero, 1'b0, 1'b0, 1'b1);
        end else begin
          if (a.t != x.t) begin
            pieces[n] = box_from_corners(a.l, a.t, a.r, x.t);
            n++;
          end
          if (a.b != x.b) begin
            pieces[n] = box_from_corners(a.l, x.b, a.r, a.b);
            n++;
          end
          if (a.l != x.l) begin
            pieces[n] = box_from_corners(a.l, x.t, x.l, x.b);
            n++;
          end
          if (a.r != x.r) begin
            pieces[n] = box_from_corners(x.r, x.t, a.r, x.b);
            n++;
          end
          for (int k = 0; k < n; k++) begin
            push_rect(pieces[k], 1'b0, 1'b1, k == n - 1);
          end
        end
      end
      default: begin
        push_rect(box_from_corners(a.l, a.t, a.r, a.b), 1'b0, 1'b1, 1'b1);
      end
    endcase
  endfunction

  function automatic logic signed [COORD_BITS-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0: return COORD_BITS'(COORD_MIN);
      1: return COORD_BITS'(COORD_MAX);
      2: return '1;
      default: return '0;
    endcase
  endfunction

  function automatic rect_req_t random_request();
    rect_req_t q;
    int style, cx, cy, al, at, bl, bt;
    q = '0;
    q.command = rgu_pkg::cmd_t'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) begin
      q.command = rgu_pkg::CMD_SUBTRACT;
    end
    style = $urandom_range(0, 9);
    q.shift_x = COORD_BITS'($urandom);
    q.shift_y = COORD_BITS'($urandom);
    q.margin = COORD_BITS'($urandom);
    if (style < 2) begin
      q.a_left = COORD_BITS'($urandom);
      q.a_right = COORD_BITS'($urandom);
      q.a_top = COORD_BITS'($urandom);
      q.a_bottom = COORD_BITS'($urandom);
      q.b_left = COORD_BITS'($urandom);
      q.b_right = COORD_BITS'($urandom);
      q.b_top = COORD_BITS'($urandom);
      q.b_bottom = COORD_BITS'($urandom);
    end else if (style == 2) begin
      q.a_left = extreme_coord();
      q.a_right = extreme_coord();
      q.a_top = extreme_coord();
      q.a_bottom = extreme_coord();
      q.b_left = extreme_coord();
      q.b_right = extreme_coord();
      q.b_top = extreme_coord();
      q.b_bottom = extreme_coord();
      q.margin = extreme_coord();
    end else begin
      // Rectangles clustered round one point, so that they overlap in every way.
      cx = $urandom_range(0, 64000) - 32000;
      cy = $urandom_range(0, 64000) - 32000;
      al = cx + $urandom_range(0, 40);
      at = cy + $urandom_range(0, 40);
      bl = cx + $urandom_range(0, 60);
      bt = cy + $urandom_range(0, 60);
      q.a_left = COORD_BITS'(al);
      q.a_right = COORD_BITS'(al + $urandom_range(0, 50));
      q.a_top = COORD_BITS'(at);
      q.a_bottom = COORD_BITS'(at + $urandom_range(0, 50));
      q.b_left = COORD_BITS'(bl);
      q.b_right = COORD_BITS'(bl + $urandom_range(0, 50));
      q.b_top = COORD_BITS'(bt);
      q.b_bottom = COORD_BITS'(bt + $urandom_range(0, 50));
      if (style == 3) begin
        {q.a_left, q.a_right} = {q.a_right, q.a_left};
      end
      if (style == 4) begin
        {q.b_top, q.b_bottom} = {q.b_bottom, q.b_top};
      end
      if (style > 5) begin
        q.shift_x = COORD_BITS'($urandom_range(0, 100) - 50);
        q.shift_y = COORD_BITS'($urandom_range(0, 100) - 50);
        q.margin = COORD_BITS'($urandom_range(0, 24) - 12);
      end
    end
    return q;
  endfunction

  task automatic add_row(rgu_pkg::cmd_t c, int al, int ar, int at, int ab,
                         int bl, int br, int bt, int bb, int sx, int sy, int mg);
    stim_row_t row;
    row = '0;
    row.req.command = c;
    row.req.a_left = COORD_BITS'(al);
    row.req.a_right = COORD_BITS'(ar);
    row.req.a_top = COORD_BITS'(at);
    row.req.a_bottom = COORD_BITS'(ab);
    row.req.b_left = COORD_BITS'(bl);
    row.req.b_right = COORD_BITS'(br);
    row.req.b_top = COORD_BITS'(bt);
    row.req.b_bottom = COORD_BITS'(bb);
    row.req.shift_x = COORD_BITS'(sx);
    row.req.shift_y = COORD_BITS'(sy);
    row.req.margin = COORD_BITS'(mg);
    stim_table.insert(stim_table.size(), row);
  endtask

  task automatic typed_result(int left_v, int right_v, int top_v, int bottom_v,
                              logic flag, logic valid, logic sat);
    stim_row_t row;
    row = stim_table[stim_table.size() - 1];
    row.has_typed = 1'b1;
    row.typed.out_left = COORD_BITS'(left_v);
    row.typed.out_right = COORD_BITS'(right_v);
    row.typed.out_top = COORD_BITS'(top_v);
    row.typed.out_bottom = COORD_BITS'(bottom_v);
    row.typed.test_flag = flag;
    row.typed.rect_valid = valid;
    row.typed.saturated = sat;
    row.typed.last_piece = 1'b1;
    stim_table[stim_table.size() - 1] = row;
  endtask

  task automatic send_request(stim_row_t row);
    start <= 1'b1;
    drv <= row.req;
    do @(posedge clk); while (busy);
    if (row.has_typed) begin
      rects_awaited.insert(rects_awaited.size(), row.typed);
    end else begin
      predict_rectangles(row.req);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (rects_awaited.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    rect_result_t want;
    if (!rst && strobe) begin
      if (rects_awaited.size() == 0) begin
        $error("result with no transaction awaiting it: out_left %0d, last_piece %0d",
               out_left, last_piece);
        error_count++;
      end else begin
        want = rects_awaited.pop_front();
        check_field("out_left", $signed(want.out_left), out_left);
        check_field("out_right", $signed(want.out_right), out_right);
        check_field("out_top", $signed(want.out_top), out_top);
        check_field("out_bottom", $signed(want.out_bottom), out_bottom);
        check_field("test_flag", want.test_flag, test_flag);
        check_field("rect_valid", want.rect_valid, rect_valid);
        check_field("saturated", want.saturated, saturated);
        check_field("last_piece", want.last_piece, last_piece);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    bit calm;
    add_row(rgu_pkg::CMD_NORMALIZE, 10, -5, 20, -3, 0, 0, 0, 0, 0, 0, 0);
    typed_result(-5, 10, -3, 20, 1'b0, 1'b1, 1'b0);
    add_row(rgu_pkg::CMD_NORMALIZE, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0, 0);
    add_row(rgu_pkg::CMD_INTERSECT, 50, 60, 0, 10, 0, 10, 0, 10, 0, 0, 0);
    add_row(rgu_pkg::CMD_INTERSECT, 0, 10, -20, -10, 50, 60, 0, 10, 0, 0, 0);
    add_row(rgu_pkg::CMD_INTERSECT, -32768, 32767, -32768, 32767, -100, 100, 5, 6,
            0, 0, 0);
    add_row(rgu_pkg::CMD_JOIN, -32768, 0, 0, 32767, 0, 32767, -32768, 0, 0, 0, 0);
    add_row(rgu_pkg::CMD_MOVE, 100, 200, 0, 5, 0, 0, 0, 0, 32767, 0, 0);
    typed_result(32767, 32767, 0, 5, 1'b0, 1'b1, 1'b1);
    add_row(rgu_pkg::CMD_MOVE, -1, 0, -32768, 32767, 0, 0, 0, 0, -32768, -32768, 0);
    typed_result(-32768, -32768, -32768, -1, 1'b0, 1'b1, 1'b1);
    add_row(rgu_pkg::CMD_MOVE, 5, 10, -7, 3, 0, 0, 0, 0, 300, -400, 0);
    add_row(rgu_pkg::CMD_INNER, 0, 10, 0, 10, 0, 10, 0, 10, 0, 0, 0);
    typed_result(0, 0, 0, 0, 1'b1, 1'b0, 1'b0);
    add_row(rgu_pkg::CMD_INNER, 0, 10, 0, 10, 5, 15, 2, 8, 0, 0, 0);
    add_row(rgu_pkg::CMD_NEAR_INNER, 0, 10, 0, 10, -5, 15, -5, 15, 0, 0, 5);
    add_row(rgu_pkg::CMD_NEAR_INNER, -32768, 32767, -32768, 32767,
            -32768, 32767, -32768, 32767, 0, 0, 32767);
    add_row(rgu_pkg::CMD_NEAR_INNER, -32768, 32767, -32768, 32767,
            -5, 5, -5, 5, 0, 0, -32768);
    add_row(rgu_pkg::CMD_NEAR_INNER, 0, 10, 0, 10, 0, 0, 0, 0, 0, 0, -20);
    add_row(rgu_pkg::CMD_CROSSED, 0, 10, 0, 10, 20, 30, 0, 10, 0, 0, 0);
    typed_result(0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(rgu_pkg::CMD_CROSSED, 0, 10, 0, 10, 5, 15, 5, 15, 0, 0, 0);
    add_row(rgu_pkg::CMD_CROSSED, 0, 10, 0, 10, 5, 5, 0, 10, 0, 0, 0);
    add_row(rgu_pkg::CMD_SUBTRACT, 0, 10, 0, 10, -5, 20, -5, 20, 0, 0, 0);
    typed_result(0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(rgu_pkg::CMD_SUBTRACT, 0, 10, 0, 10, 20, 30, 0, 10, 0, 0, 0);
    typed_result(0, 10, 0, 10, 1'b0, 1'b1, 1'b0);
    add_row(rgu_pkg::CMD_SUBTRACT, 0, 100, 0, 100, 25, 75, 25, 75, 0, 0, 0);
    add_row(rgu_pkg::CMD_SUBTRACT, 0, 100, 0, 100, 50, 200, -10, 50, 0, 0, 0);
    add_row(rgu_pkg::CMD_SUBTRACT, 100, 0, 0, 100, 25, 75, 25, 75, 0, 0, 0);
    add_row(rgu_pkg::CMD_SUBTRACT, -32768, 32767, -32768, 32767, -10, 10, -10, 10,
            0, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[k]) begin
      send_request(stim_table[k]);
      if ($urandom_range(0, 99) < 22) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    drain_results();

    // The middle stretch runs back to back so that subtract stalls meet a full pipeline.
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      calm = (k >= 150 && k < 260);
      if (k == 300) begin
        drain_results();
      end
      row = '0;
      row.req = random_request();
      send_request(row);
      if (!calm && $urandom_range(0, 99) < 22) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    drain_results();
    repeat (12) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rgu_pkg.sv
hw/rtl/rgu_calc.sv
hw/rtl/rectangle_geometry_unit.sv
dv/testbench.sv
